// ===== rtl/core/at_response_line_classifier_defines.svh =====
// Assertion helpers shared by the classifier modules.
// Each use expects clk and arst_n in scope.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define ARLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in this cycle implies the property in the next one.
`define ARLC_ASSERT_NEXT(lbl, cond, prop, msg) \
	`ARLC_ASSERT(lbl, (cond) |=> (prop), msg)

// Condition implies the property in the same cycle.
`define ARLC_ASSERT_NOW(lbl, cond, prop, msg) \
	`ARLC_ASSERT(lbl, (cond) |-> (prop), msg)

`endif

// ===== rtl/core/arlc_pkg.sv =====
package arlc_pkg;

	localparam int DEF_LINE_BUFFER_BYTES = 256;
	localparam int DEF_WINDOW_BYTES      = 16;
	localparam int DEF_QUEUE_DEPTH       = 4;

	localparam logic [7:0] CHAR_CR  = 8'h0d;
	localparam logic [7:0] CHAR_LF  = 8'h0a;
	localparam logic [7:0] CHAR_EQ  = 8'h3d;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_LA  = 8'h61;
	localparam logic [7:0] CHAR_LZ  = 8'h7a;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam int PAT_COUNT   = 4;
	localparam int PAT_MAX_LEN = 16;

	localparam int PAT_ACK  = 0;
	localparam int PAT_NACK = 1;
	localparam int PAT_FAIL = 2;
	localparam int PAT_FACE = 3;

	// Right-justified: the last character of each pattern sits in bits [7:0].
	localparam logic [PAT_MAX_LEN*8-1:0] PAT_TEXT [PAT_COUNT] = '{
		"AT+PWOFFRSP=ACK",
		"AT+PWOFFRSP=NACK",
		"AT+FACERES=FAIL",
		"AT+FACERES="
	};
	localparam logic [4:0] PAT_LEN [PAT_COUNT] = '{5'd15, 5'd16, 5'd15, 5'd11};

	typedef enum logic [1:0] {
		EV_IDLE       = 2'd0,
		EV_UNLOCK     = 2'd1,
		EV_PWOFF_ACK  = 2'd2,
		EV_PWOFF_NACK = 2'd3
	} event_t;

	typedef struct packed {
		event_t     event_code;
		logic [7:0] line_length;
	} result_t;

endpackage

// ===== rtl/core/arlc_front.sv =====
`include "at_response_line_classifier_defines.svh"

module arlc_front #(
	parameter int LINE_BUFFER_BYTES = arlc_pkg::DEF_LINE_BUFFER_BYTES,
	parameter int WINDOW_BYTES      = arlc_pkg::DEF_WINDOW_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output arlc_pkg::result_t res
);

	localparam int CW  = $clog2(LINE_BUFFER_BYTES);
	localparam int NXW = (CW + 1 > 8) ? CW + 1 : 8;

	logic [CW-1:0]  count_q;
	logic [7:0]     prev_q;
	logic           equals_q;
	logic           nul_q;
	logic [7:0]     win_q [WINDOW_BYTES];
	logic [arlc_pkg::PAT_COUNT-1:0] found_q;

	logic [NXW-1:0] cnt_nx;
	logic           overflow;
	logic           shift;
	logic           equals_nx;
	logic [7:0]     bt;
	logic [7:0]     win_nx [WINDOW_BYTES];
	logic [arlc_pkg::PAT_COUNT-1:0] hit;
	logic [arlc_pkg::PAT_COUNT-1:0] found_nx;
	logic           eol;
	arlc_pkg::event_t code;

	assign cnt_nx   = NXW'(count_q) + NXW'(1);
	assign overflow = (cnt_nx == NXW'(LINE_BUFFER_BYTES));

	// Case folding ahead of the first '=', and the NUL cutoff.
	always_comb begin
		shift     = 1'b0;
		equals_nx = equals_q;
		bt        = rx_byte;
		if (!nul_q && rx_byte != arlc_pkg::CHAR_NUL) begin
			shift = 1'b1;
			if (!equals_q) begin
				if (rx_byte == arlc_pkg::CHAR_EQ) begin
					equals_nx = 1'b1;
				end else if (rx_byte >= arlc_pkg::CHAR_LA && rx_byte <= arlc_pkg::CHAR_LZ) begin
					bt = rx_byte - arlc_pkg::CASE_OFS;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
			win_nx[i] = win_q[i+1];
		end
		win_nx[WINDOW_BYTES-1] = bt;
	end

	// Each pattern is compared against the tail of the shifted window.
	always_comb begin
		for (int p = 0; p < arlc_pkg::PAT_COUNT; p++) begin
			hit[p] = 1'b1;
			for (int j = 0; j < arlc_pkg::PAT_MAX_LEN; j++) begin
				if (5'(j) < arlc_pkg::PAT_LEN[p] &&
				    win_nx[WINDOW_BYTES-1-j] != arlc_pkg::PAT_TEXT[p][j*8 +: 8]) begin
					hit[p] = 1'b0;
				end
			end
		end
	end

	assign found_nx = shift ? (found_q | hit) : found_q;

	assign eol = (cnt_nx >= NXW'(2)) &&
	             ((prev_q == arlc_pkg::CHAR_CR && rx_byte == arlc_pkg::CHAR_LF) ||
	              (prev_q == arlc_pkg::CHAR_LF && rx_byte == arlc_pkg::CHAR_CR));

	always_comb begin
		if (found_nx[arlc_pkg::PAT_ACK]) begin
			code = arlc_pkg::EV_PWOFF_ACK;
		end else if (found_nx[arlc_pkg::PAT_NACK]) begin
			code = arlc_pkg::EV_PWOFF_NACK;
		end else if (found_nx[arlc_pkg::PAT_FAIL]) begin
			code = arlc_pkg::EV_IDLE;
		end else if (found_nx[arlc_pkg::PAT_FACE]) begin
			code = arlc_pkg::EV_UNLOCK;
		end else begin
			code = arlc_pkg::EV_IDLE;
		end
	end

	assign res_valid        = accept && !overflow && eol;
	assign res.event_code   = code;
	assign res.line_length  = cnt_nx[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			prev_q   <= '0;
			equals_q <= 1'b0;
			nul_q    <= 1'b0;
			found_q  <= '0;
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			if (overflow || eol) begin
				// Drop or finish the line: start the next one clean.
				count_q  <= '0;
				prev_q   <= '0;
				equals_q <= 1'b0;
				nul_q    <= 1'b0;
				found_q  <= '0;
				for (int i = 0; i < WINDOW_BYTES; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				count_q  <= cnt_nx[CW-1:0];
				prev_q   <= rx_byte;
				equals_q <= equals_nx;
				found_q  <= found_nx;
				if (!nul_q && rx_byte == arlc_pkg::CHAR_NUL) begin
					nul_q <= 1'b1;
				end
				if (shift) begin
					for (int i = 0; i < WINDOW_BYTES; i++) begin
						win_q[i] <= win_nx[i];
					end
				end
			end
		end
	end

	`ARLC_ASSERT_NEXT(a_clear_after_eol, res_valid, count_q == '0 && found_q == '0, "line state not cleared after a line end")
	`ARLC_ASSERT_NEXT(a_clear_on_drop, accept && overflow, count_q == '0 && !nul_q, "line state not cleared on a full buffer")
	`ARLC_ASSERT_NOW(a_len_min, res_valid, res.line_length != 8'd0 && res.line_length != 8'd1, "line end reported with fewer than two bytes")

endmodule

// ===== rtl/core/arlc_queue.sv =====
`include "at_response_line_classifier_defines.svh"

module arlc_queue #(
	parameter int DEPTH = arlc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  arlc_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output arlc_pkg::result_t out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	arlc_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] count_q;
	logic          pop;

	assign full      = (count_q == NW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	`ARLC_ASSERT_NOW(a_no_push_full, push, !full, "item pushed into a full queue")
	`ARLC_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + NW'(1), "queue count did not advance")
	`ARLC_ASSERT(a_count_max, count_q <= NW'(DEPTH), "queue count above its depth")

endmodule

// ===== rtl/core/at_response_line_classifier.sv =====
// Serial response line classifier.
// Input channel (in_valid, in_ready, rx_byte): one received byte per item.
// Output channel (out_valid, out_ready, event_code, line_length): one item
// for each completed line, ending on CR LF or LF CR with at least two bytes.
// event_code: 0 idle, 1 unlock, 2 power-off ack, 3 power-off nack.
// Throughput: one byte per cycle unless the queue is full. The framer
// and pattern matcher update in the cycle the byte is taken; a line end
// writes its result into a small queue, which registers it for out_valid.
// A line that reaches LINE_BUFFER_BYTES is dropped without a result.
// When the receiver stalls, results wait in the queue (QUEUE_DEPTH entries)
// while bytes keep flowing; in_ready drops only when the queue is full.
// Reset clears the line state and empties the queue; in_ready is high
// from the first cycle after reset.
module at_response_line_classifier #(
	parameter int LINE_BUFFER_BYTES = arlc_pkg::DEF_LINE_BUFFER_BYTES,
	parameter int WINDOW_BYTES      = arlc_pkg::DEF_WINDOW_BYTES,
	parameter int QUEUE_DEPTH       = arlc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_code,
	output logic [7:0] line_length
);

	logic              accept;
	logic              full;
	logic              res_valid;
	arlc_pkg::result_t res;
	arlc_pkg::result_t out_data;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	arlc_front #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES),
		.WINDOW_BYTES     (WINDOW_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res      (res)
	);

	arlc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.full     (full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign event_code  = out_data.event_code;
	assign line_length = out_data.line_length;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	localparam int LINE_BYTES   = arlc_pkg::DEF_LINE_BUFFER_BYTES;
	localparam int WIN          = arlc_pkg::DEF_WINDOW_BYTES;
	localparam int TOTAL_BYTES  = 1300;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 16;

	typedef logic [7:0] byte_q_t[$];
	typedef enum {CHECK_MODEL, CHECK_TYPED, CHECK_NONE} check_t;
	typedef enum {TERM_NONE, TERM_CRLF, TERM_LFCR} term_t;
	typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_HOLD} ready_mode_t;

	typedef struct {
		string             head;
		logic [7:0]        fill;
		int                fill_n;
		string             tail;
		term_t             term;
		check_t            chk;
		arlc_pkg::result_t typed;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] event_code;
	logic [7:0] line_length;

	// classifier copy: line state
	int         line_bytes;
	logic [7:0] last_byte;
	bit         eq_seen;
	bit         nul_seen;
	logic [7:0] match_win [WIN];
	logic [3:0] found;

	arlc_pkg::result_t pending_results[$];
	stim_row_t         directed_rows[$];
	int                mismatch_count = 0;
	int                sent_bytes = 0;
	int                burst_left = 0;
	bit                valid_dropped = 1'b1;
	int                idle_cycles = 0;
	ready_mode_t       ready_mode = RDY_ALWAYS;
	int                mode_left = 0;
	arlc_pkg::result_t want;

	at_response_line_classifier i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.line_length(line_length)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic string pattern_text(input int p);
		case (p)
			arlc_pkg::PAT_ACK:  return "AT+PWOFFRSP=ACK";
			arlc_pkg::PAT_NACK: return "AT+PWOFFRSP=NACK";
			arlc_pkg::PAT_FAIL: return "AT+FACERES=FAIL";
			default:            return "AT+FACERES=";
		endcase
	endfunction

	function automatic void clear_line();
		line_bytes = 0;
		last_byte = 8'h00;
		eq_seen = 1'b0;
		nul_seen = 1'b0;
		found = '0;
		for (int i = 0; i < WIN; i++)
			match_win[i] = 8'h00;
	endfunction

	function automatic bit window_ends_with(input int p);
		string      s;
		int         n;
		logic [7:0] ch;
		s = pattern_text(p);
		n = s.len();
		if (n > WIN)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			ch = s[i];
			if (match_win[WIN - n + i] != ch)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit predict_line_end(input logic [7:0] b,
	                                        output arlc_pkg::result_t res);
		logic [7:0] prev_b;
		logic [7:0] t;
		bit         pair;
		res = '0;
		prev_b = last_byte;
		line_bytes++;
		if (line_bytes >= LINE_BYTES) begin
			clear_line();
			return 1'b0;
		end
		if (!nul_seen) begin
			if (b == arlc_pkg::CHAR_NUL) begin
				nul_seen = 1'b1;
			end else begin
				t = b;
				if (!eq_seen) begin
					if (b == arlc_pkg::CHAR_EQ)
						eq_seen = 1'b1;
					else if (b >= arlc_pkg::CHAR_LA && b <= arlc_pkg::CHAR_LZ)
						t = b - arlc_pkg::CASE_OFS;
				end
				for (int i = 0; i < WIN - 1; i++)
					match_win[i] = match_win[i + 1];
				match_win[WIN - 1] = t;
				for (int p = 0; p < arlc_pkg::PAT_COUNT; p++)
					if (window_ends_with(p))
						found[p] = 1'b1;
			end
		end
		last_byte = b;
		pair = (prev_b == arlc_pkg::CHAR_CR && b == arlc_pkg::CHAR_LF) ||
		       (prev_b == arlc_pkg::CHAR_LF && b == arlc_pkg::CHAR_CR);
		if (line_bytes < 2 || !pair)
			return 1'b0;
		if (found[arlc_pkg::PAT_ACK])
			res.event_code = arlc_pkg::EV_PWOFF_ACK;
		else if (found[arlc_pkg::PAT_NACK])
			res.event_code = arlc_pkg::EV_PWOFF_NACK;
		else if (found[arlc_pkg::PAT_FAIL])
			res.event_code = arlc_pkg::EV_IDLE;
		else if (found[arlc_pkg::PAT_FACE])
			res.event_code = arlc_pkg::EV_UNLOCK;
		else
			res.event_code = arlc_pkg::EV_IDLE;
		res.line_length = line_bytes[7:0];
		clear_line();
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input check_t chk,
	                         input arlc_pkg::result_t typed);
		arlc_pkg::result_t res;
		bit                got;
		in_valid <= 1'b1;
		rx_byte <= b;
		valid_dropped = 1'b0;
		do @(posedge clk); while (in_ready !== 1'b1);
		sent_bytes++;
		got = predict_line_end(b, res);
		if (chk == CHECK_TYPED)
			pending_results.push_back(typed);
		else if (chk == CHECK_MODEL && got)
			pending_results.push_back(res);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                          : $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				valid_dropped = 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	endtask

	task automatic send_line(input byte_q_t line_q, input check_t last_chk,
	                         input arlc_pkg::result_t typed);
		foreach (line_q[i])
			send_byte(line_q[i], (i == line_q.size() - 1) ? last_chk : CHECK_MODEL, typed);
	endtask

	function automatic void append_term(ref byte_q_t q, input term_t term);
		if (term == TERM_CRLF) begin
			q.push_back(arlc_pkg::CHAR_CR);
			q.push_back(arlc_pkg::CHAR_LF);
		end else if (term == TERM_LFCR) begin
			q.push_back(arlc_pkg::CHAR_LF);
			q.push_back(arlc_pkg::CHAR_CR);
		end
	endfunction

	function automatic void add_row(input string head, input logic [7:0] fill,
	                                input int fill_n, input string tail, input term_t term,
	                                input check_t chk, input arlc_pkg::event_t code,
	                                input int len);
		stim_row_t r;
		r.head = head;
		r.fill = fill;
		r.fill_n = fill_n;
		r.tail = tail;
		r.term = term;
		r.chk = chk;
		r.typed.event_code = code;
		r.typed.line_length = len[7:0];
		directed_rows.push_back(r);
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(8'h20, 8'h7e));
	endfunction

	function automatic term_t random_term();
		return ($urandom_range(0, 1) == 0) ? TERM_CRLF : TERM_LFCR;
	endfunction

	function automatic byte_q_t random_line();
		byte_q_t    q;
		string      s;
		int         kind;
		int         n;
		bit         eq_passed;
		logic [7:0] ch;
		kind = $urandom_range(0, 99);
		if (kind < 2) begin
			// run near or past the buffer size
			n = $urandom_range(LINE_BYTES - 6, LINE_BYTES);
			repeat (n) q.push_back(8'($urandom_range(8'h41, 8'h5a)));
			append_term(q, random_term());
		end else if (kind < 25) begin
			n = $urandom_range(1, 24);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 0)
				append_term(q, random_term());
		end else begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 6)) q.push_back(printable());
			s = pattern_text($urandom_range(0, arlc_pkg::PAT_COUNT - 1));
			eq_passed = 1'b0;
			for (int i = 0; i < s.len(); i++) begin
				ch = s[i];
				if (ch == arlc_pkg::CHAR_EQ)
					eq_passed = 1'b1;
				else if (!eq_passed && ch >= 8'h41 && ch <= 8'h5a && $urandom_range(0, 1) == 0)
					ch = ch + arlc_pkg::CASE_OFS;
				q.push_back(ch);
			end
			if (kind < 35) begin
				// break the pattern: truncate or corrupt one byte
				if ($urandom_range(0, 1) == 0)
					repeat ($urandom_range(1, 4)) void'(q.pop_back());
				else
					q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 9) == 0)
				q.insert($urandom_range(0, q.size()), arlc_pkg::CHAR_NUL);
			repeat ($urandom_range(0, 5)) q.push_back(printable());
			append_term(q, ($urandom_range(0, 9) == 0) ? TERM_NONE : random_term());
		end
		return q;
	endfunction

	// receiver: check each result item, then pick the next ready value
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result code=%0d len=%0d",
				                          event_code, line_length));
			end else begin
				want = pending_results.pop_front();
				if (event_code !== want.event_code)
					report_mismatch($sformatf("event_code %0d, expected %0d",
					                          event_code, want.event_code));
				if (line_length !== want.line_length)
					report_mismatch($sformatf("line_length %0d, expected %0d",
					                          line_length, want.line_length));
			end
		end
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(4, 60);
		end
		mode_left--;
		case (ready_mode)
			RDY_ALWAYS: out_ready <= 1'b1;
			RDY_HALF:   out_ready <= 1'($urandom_range(0, 1));
			RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:    out_ready <= (mode_left < 2);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		byte_q_t line_q;
		string   s;
		clear_line();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row("", 8'h00, 0, "", TERM_CRLF, CHECK_TYPED, arlc_pkg::EV_IDLE, 2);
		add_row("", 8'h00, 0, "", TERM_LFCR, CHECK_TYPED, arlc_pkg::EV_IDLE, 2);
		add_row("AT+PWOFFRSP=ACK", 8'h00, 0, "", TERM_CRLF, CHECK_TYPED,
		        arlc_pkg::EV_PWOFF_ACK, 17);
		add_row("at+pwoffrsp=NACK", 8'h00, 0, "", TERM_LFCR, CHECK_TYPED,
		        arlc_pkg::EV_PWOFF_NACK, 18);
		add_row("AT+FACERES=FAIL", 8'h00, 0, "", TERM_CRLF, CHECK_TYPED,
		        arlc_pkg::EV_IDLE, 17);
		add_row("AT+FACERES=1,ok", 8'h00, 0, "", TERM_LFCR, CHECK_TYPED,
		        arlc_pkg::EV_UNLOCK, 17);
		add_row("At+FaceRes=fail", 8'h00, 0, "", TERM_CRLF, CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		add_row("x=at+faceres=", 8'h00, 0, "", TERM_CRLF, CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		// NUL in the middle blocks the match
		add_row("AT+FACE", arlc_pkg::CHAR_NUL, 1, "RES=", TERM_CRLF, CHECK_MODEL,
		        arlc_pkg::EV_IDLE, 0);
		add_row("", 8'hff, 3, "AT+PWOFFRSP=ACK", TERM_LFCR, CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		add_row("", 8'he1, 2, "\x80AT+FACERES=", TERM_CRLF, CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		add_row("", arlc_pkg::CHAR_CR, 1, "", TERM_CRLF, CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		add_row("AT+PWOFFRSP=ACKAT+FACERES=FAIL", 8'h00, 0, "", TERM_CRLF,
		        CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		add_row("AT+FACERES=FAILAT+PWOFFRSP=NACK", 8'h00, 0, "", TERM_LFCR,
		        CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		add_row("abc", 8'h00, 0, "", TERM_NONE, CHECK_MODEL, arlc_pkg::EV_IDLE, 0);
		add_row("", 8'h00, 0, "", TERM_LFCR, CHECK_TYPED, arlc_pkg::EV_IDLE, 5);
		// longest line that still completes, then one that overflows
		add_row("", 8'h78, LINE_BYTES - 3, "", TERM_CRLF, CHECK_TYPED, arlc_pkg::EV_IDLE, 255);
		add_row("", 8'h79, LINE_BYTES - 2, "", TERM_CRLF, CHECK_NONE, arlc_pkg::EV_IDLE, 0);
		add_row("AT+FACERES=", 8'h00, 0, "", TERM_CRLF, CHECK_TYPED, arlc_pkg::EV_UNLOCK, 13);

		foreach (directed_rows[r]) begin
			line_q = {};
			s = directed_rows[r].head;
			for (int i = 0; i < s.len(); i++)
				line_q.push_back(s[i]);
			repeat (directed_rows[r].fill_n) line_q.push_back(directed_rows[r].fill);
			s = directed_rows[r].tail;
			for (int i = 0; i < s.len(); i++)
				line_q.push_back(s[i]);
			append_term(line_q, directed_rows[r].term);
			send_line(line_q, directed_rows[r].chk, directed_rows[r].typed);
		end

		while (sent_bytes < TOTAL_BYTES)
			send_line(random_line(), CHECK_MODEL, '0);

		if (!valid_dropped)
			in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
